>>> hw/rtl/ltfr_pkg.sv
package ltfr_pkg;

	localparam int SESSION_COUNT_DEF    = 64;
	localparam int MACS_PER_SESSION_DEF = 8;

	localparam int CMD_W      = 4;
	localparam int SESS_FLD_W = 6;
	localparam int MAC_W      = 48;
	localparam int MASK_W     = 64;
	localparam int SLOT_OUT_W = 3;
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 80;

	localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

	typedef enum logic [CMD_W-1:0] {
		CMD_CHAT       = 4'd0,
		CMD_TUNNEL     = 4'd1,
		CMD_USER_LIST  = 4'd2,
		CMD_INFO       = 4'd3,
		CMD_PING       = 4'd4,
		CMD_PING_REPLY = 4'd5,
		CMD_CONNECT    = 4'd6,
		CMD_DISCONNECT = 4'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_LEARN,
		ST_SCAN,
		ST_DRAIN,
		ST_RESP
	} state_t;

endpackage

>>> hw/rtl/learning_tunnel_frame_router_unit.sv
// Flow: each accepted item passes through EVAL and then RESP, where its result is registered;
// a tunnel frame from a connected source also passes LEARN and, unless it is a broadcast,
// SCAN and DRAIN, the table scan that reads one session row per cycle.
// One item is in work at a time: the next item is taken only after the result of the last one
// is registered, and RESP holds the item while the output is stalled.
// Reset (arst_n low, asynchronous) disconnects every session and empties every MAC table
// at once through per-session fill counts; the MAC memory itself needs no clearing pass.
module learning_tunnel_frame_router_unit #(
	parameter int SESSION_COUNT    = ltfr_pkg::SESSION_COUNT_DEF,
	parameter int MACS_PER_SESSION = ltfr_pkg::MACS_PER_SESSION_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// source_session, target_session, dest_mac, src_mac, zero fill.
	input  logic [ltfr_pkg::IN_DATA_W-1:0]  s_tdata,
	// command.
	input  logic [ltfr_pkg::CMD_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// dest_mask, origin_session, learned, learn_slot, table_full, unsupported, zero fill.
	output logic [ltfr_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int SESS_W = $clog2(SESSION_COUNT);
	localparam int FILL_W = $clog2(MACS_PER_SESSION + 1);
	localparam int SLOT_W = (MACS_PER_SESSION > 1) ? $clog2(MACS_PER_SESSION) : 1;
	localparam int MAC_W  = ltfr_pkg::MAC_W;
	localparam int MASK_W = ltfr_pkg::MASK_W;

	ltfr_pkg::state_t state_q, state_next;

	logic [ltfr_pkg::CMD_W-1:0]      cmd_q;
	logic [ltfr_pkg::SESS_FLD_W-1:0] src_q;
	logic [ltfr_pkg::SESS_FLD_W-1:0] tgt_q;
	logic [MAC_W-1:0]                dmac_q;
	logic [MAC_W-1:0]                smac_q;

	logic [SESSION_COUNT-1:0] connected_q;
	logic [FILL_W-1:0]        fill_q [SESSION_COUNT];
	logic [SESS_W-1:0]        sc_q;

	logic [MACS_PER_SESSION-1:0][MAC_W-1:0] mac_mem [SESSION_COUNT];
	logic [MACS_PER_SESSION-1:0][MAC_W-1:0] rd_row_s1;
	logic [FILL_W-1:0]                      fill_s1;
	logic                                   conn_s1;
	logic [SESS_W-1:0]                      cmp_idx_s1;
	logic                                   cmp_valid_s1;

	logic [MASK_W-1:0]                  mask_q;
	logic [ltfr_pkg::SESS_FLD_W-1:0]    origin_q;
	logic                               learned_q;
	logic [ltfr_pkg::SLOT_OUT_W-1:0]    slot_q;
	logic                               full_q;
	logic                               unsup_q;
	logic                               m_tvalid_q;
	logic [ltfr_pkg::OUT_DATA_W-1:0]    m_tdata_q;

	logic                        src_ok, tgt_ok, src_conn, pkt_ok, tunnel_go;
	logic [SESS_W-1:0]           src_idx, tgt_idx, rd_addr;
	logic [MAC_W-1:0]            key;
	logic [MACS_PER_SESSION-1:0] hit_vec;
	logic                        hit_any, slots_full, learn_new, bcast, out_load, scan_hit;
	logic [MASK_W-1:0]           conn64, src_bit;

	always_comb begin
		src_ok    = 32'(src_q) < SESSION_COUNT;
		tgt_ok    = 32'(tgt_q) < SESSION_COUNT;
		src_idx   = src_q[SESS_W-1:0];
		tgt_idx   = tgt_q[SESS_W-1:0];
		src_conn  = connected_q[src_idx];
		pkt_ok    = src_ok && src_conn;
		tunnel_go = (cmd_q == ltfr_pkg::CMD_TUNNEL) && pkt_ok;
		conn64    = MASK_W'(connected_q);
		src_bit   = MASK_W'(1) << src_q;
		bcast     = dmac_q == ltfr_pkg::MAC_BCAST;
		rd_addr   = (state_q == ltfr_pkg::ST_SCAN) ? sc_q : src_idx;

		// Shared compare bank: one stored row against the key, limited to filled slots.
		key = (state_q == ltfr_pkg::ST_LEARN) ? smac_q : dmac_q;
		for (int m = 0; m < MACS_PER_SESSION; m++) begin
			hit_vec[m] = (FILL_W'(m) < fill_s1) && (rd_row_s1[m] == key);
		end
		hit_any    = |hit_vec;
		slots_full = fill_s1 == FILL_W'(MACS_PER_SESSION);
		learn_new  = (state_q == ltfr_pkg::ST_LEARN) && !hit_any && !slots_full;
		scan_hit   = cmp_valid_s1 && hit_any && conn_s1 && (cmp_idx_s1 != src_idx);

		s_tready = state_q == ltfr_pkg::ST_IDLE;
		out_load = 1'b0;
		state_next = state_q;
		unique case (state_q)
			ltfr_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_next = ltfr_pkg::ST_EVAL;
				end
			end
			ltfr_pkg::ST_EVAL: begin
				state_next = tunnel_go ? ltfr_pkg::ST_LEARN : ltfr_pkg::ST_RESP;
			end
			ltfr_pkg::ST_LEARN: begin
				state_next = bcast ? ltfr_pkg::ST_RESP : ltfr_pkg::ST_SCAN;
			end
			ltfr_pkg::ST_SCAN: begin
				if (sc_q == SESS_W'(SESSION_COUNT - 1)) begin
					state_next = ltfr_pkg::ST_DRAIN;
				end
			end
			ltfr_pkg::ST_DRAIN: begin
				state_next = ltfr_pkg::ST_RESP;
			end
			ltfr_pkg::ST_RESP: begin
				if (!m_tvalid_q || m_tready) begin
					out_load   = 1'b1;
					state_next = ltfr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = ltfr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ltfr_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			connected_q  <= '0;
			sc_q         <= '0;
			cmp_valid_s1 <= 1'b0;
			m_tvalid_q   <= 1'b0;
			for (int s = 0; s < SESSION_COUNT; s++) begin
				fill_q[s] <= '0;
			end
		end else begin
			cmp_valid_s1 <= state_q == ltfr_pkg::ST_SCAN;
			if (state_q == ltfr_pkg::ST_EVAL && src_ok) begin
				if (cmd_q == ltfr_pkg::CMD_CONNECT) begin
					connected_q[src_idx] <= 1'b1;
					fill_q[src_idx]      <= '0;
				end else if (cmd_q == ltfr_pkg::CMD_DISCONNECT) begin
					connected_q[src_idx] <= 1'b0;
				end
			end
			if (learn_new) begin
				fill_q[src_idx] <= FILL_W'(fill_s1 + 1'b1);
			end
			if (state_q == ltfr_pkg::ST_LEARN) begin
				sc_q <= '0;
			end else if (state_q == ltfr_pkg::ST_SCAN) begin
				sc_q <= SESS_W'(sc_q + 1'b1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (learn_new) begin
			mac_mem[src_idx][fill_s1[SLOT_W-1:0]] <= smac_q;
		end
		rd_row_s1 <= mac_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		fill_s1    <= fill_q[rd_addr];
		conn_s1    <= connected_q[rd_addr];
		cmp_idx_s1 <= rd_addr;

		if (state_q == ltfr_pkg::ST_IDLE && s_tvalid) begin
			cmd_q  <= s_tuser;
			src_q  <= s_tdata[5:0];
			tgt_q  <= s_tdata[11:6];
			dmac_q <= s_tdata[59:12];
			smac_q <= s_tdata[107:60];
		end

		if (state_q == ltfr_pkg::ST_EVAL) begin
			mask_q    <= '0;
			origin_q  <= '0;
			learned_q <= 1'b0;
			slot_q    <= '0;
			full_q    <= 1'b0;
			unsup_q   <= 1'b0;
			unique case (cmd_q) inside
				ltfr_pkg::CMD_CHAT, ltfr_pkg::CMD_USER_LIST: begin
					if (pkt_ok) begin
						origin_q <= src_q;
						mask_q   <= conn64;
					end
				end
				ltfr_pkg::CMD_TUNNEL: begin
					if (pkt_ok) begin
						origin_q <= src_q;
					end
				end
				ltfr_pkg::CMD_INFO: begin
					if (pkt_ok) begin
						origin_q <= src_q;
						if (tgt_ok && connected_q[tgt_idx]) begin
							mask_q <= MASK_W'(1) << tgt_q;
						end
					end
				end
				ltfr_pkg::CMD_PING: begin
					if (pkt_ok) begin
						origin_q <= src_q;
						mask_q   <= src_bit;
					end
				end
				ltfr_pkg::CMD_PING_REPLY, ltfr_pkg::CMD_CONNECT, ltfr_pkg::CMD_DISCONNECT: begin
				end
				default: begin
					unsup_q <= 1'b1;
				end
			endcase
		end

		if (state_q == ltfr_pkg::ST_LEARN) begin
			if (!hit_any) begin
				if (slots_full) begin
					full_q <= 1'b1;
				end else begin
					learned_q <= 1'b1;
					slot_q    <= ltfr_pkg::SLOT_OUT_W'(fill_s1);
				end
			end
			mask_q <= bcast ? (conn64 & ~src_bit) : '0;
		end

		if (scan_hit) begin
			mask_q[cmp_idx_s1] <= 1'b1;
		end

		if (out_load) begin
			m_tdata_q <= {4'b0000, unsup_q, full_q, slot_q, learned_q, origin_q, mask_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
